// ===== rtl/core/dcmav_pkg.sv =====
// Package for the dual-channel moving-average voltage monitor.
// Holds the fixed field widths, scaling constants, payload structs and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcmav_pkg;

	// Fixed widths of the transaction fields.
	localparam int unsigned IN_W  = 12;
	localparam int unsigned AVG_W = 12;
	localparam int unsigned MV_W  = 14;

	// Pin span in millivolts and the external divider ratio.
	localparam int unsigned SPAN_W         = 12;
	localparam int unsigned PIN_MV_SPAN    = 3300;
	localparam int unsigned DIVIDER_FACTOR = 3;

	localparam int unsigned LANES = 2;
	localparam int unsigned LANE_BATTERY = 0;
	localparam int unsigned LANE_SOLAR   = 1;

	typedef struct packed {
		logic [IN_W-1:0] battery_sample;
		logic [IN_W-1:0] solar_sample;
	} sample_item_t;

	typedef struct packed {
		logic [AVG_W-1:0] battery_avg_raw;
		logic [AVG_W-1:0] solar_avg_raw;
		logic [MV_W-1:0]  battery_millivolts;
		logic [MV_W-1:0]  solar_millivolts;
	} average_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV_AVG,
		ST_MUL,
		ST_DIV_MV,
		ST_FINISH
	} state_t;

	// Control lines decoded from the sequencer state.
	typedef struct packed {
		logic in_ready;
		logic ram_rd_en;
		logic ram_wr_en;
		logic div_step;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcmav_stream_if.sv =====
// Valid/ready stream interface used for both channels of the monitor.
// The payload type is a parameter; the structs come from dcmav_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dcmav_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dcmav_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcmav_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 30,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dual_channel_moving_average_voltage.sv =====
// Top level of the dual-channel moving-average voltage monitor.
// Depends on dcmav_pkg, dcmav_stream_if and dcmav_ram.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the samples channel carries one battery and one solar converter
// reading. Both readings are written into a ring window of WINDOW_LEN entries, and a
// running sum is kept for each channel. The block returns exactly one transaction on the
// averages channel for every sample transaction: the truncated mean of the samples in the
// window (of the samples received so far until the window has filled), and that mean
// converted to input millivolts as (mean * 3300 / (2^SAMPLE_BITS - 1)) * 3. Both channels
// are worked in parallel lanes through a shared sequencer, and each lane divides with a
// restoring divider that retires one quotient bit per cycle. The running sum is SUM_W =
// SAMPLE_BITS + clog2(WINDOW_LEN + 1) bits wide and the scaled product DIV_W = SAMPLE_BITS +
// 12 bits wide; with the default parameters these are 17 and 24 bits. A new sample
// transaction is only taken once the sequencer has returned to idle from the previous one,
// after both bit-serial division passes. The result sits in an output register, so the
// next sample transaction is accepted while the previous result still waits to be taken.
// The windows live in a RAM whose contents are undefined after reset; an entry is only
// read back once the window has filled, so no clearing pass is needed.
module dual_channel_moving_average_voltage
	import dcmav_pkg::*;
#(
	parameter int unsigned WINDOW_LEN  = 30,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input wire logic        clk,
	input wire logic        arst_n,
	dcmav_stream_if.sink    samples,
	dcmav_stream_if.source  averages
);

	// Derived sizes.
	localparam int unsigned SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned CNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int unsigned SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int unsigned PROD_W  = SAMPLE_BITS + SPAN_W;
	localparam int unsigned DIV_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int unsigned DVR_W   = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
	localparam int unsigned STEP_W  = $clog2(DIV_W);
	localparam int unsigned EXT_W   = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
	localparam int unsigned FULL_SCALE = (1 << SAMPLE_BITS) - 1;

	// Sequencer state and its decoded controls.
	state_t state_q;
	state_t state_next;
	ctrl_t  ctrl;
	logic   ld_out;

	// Window bookkeeping.
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W:0]   slot_inc;
	logic              wrap;
	logic              full_q;
	logic              full_next;
	logic [CNT_W-1:0]  count_q;
	logic [STEP_W-1:0] step_q;

	// Per-lane datapath.
	logic [LANES-1:0][SAMPLE_BITS-1:0] sample_q;
	logic [LANES-1:0][SAMPLE_BITS-1:0] old_sample;
	logic [LANES-1:0][SUM_W-1:0]       sum_q;
	logic [LANES-1:0][SUM_W-1:0]       sum_new;
	logic [LANES-1:0][SAMPLE_BITS-1:0] avg_q;
	logic [LANES-1:0][DIV_W-1:0]       div_d_q;
	logic [LANES-1:0][DVR_W-1:0]       rem_q;
	logic [LANES-1:0][DVR_W:0]         partial;
	logic [LANES-1:0][DVR_W:0]         diff;
	logic [LANES-1:0]                  ge;
	logic [LANES-1:0][DIV_W-1:0]       div_d_next;
	logic [LANES-1:0][DVR_W-1:0]       rem_next;
	logic [LANES-1:0][MV_W-1:0]        mv;
	logic [DVR_W-1:0]                  divisor;

	// RAM word holds the solar sample above the battery sample.
	logic [LANES*SAMPLE_BITS-1:0] ram_wr_data;
	logic [LANES*SAMPLE_BITS-1:0] ram_rd_data;

	// Output register.
	logic          out_valid_q;
	average_item_t out_q;

	// Incoming samples, masked to SAMPLE_BITS.
	logic [EXT_W-1:0] battery_ext;
	logic [EXT_W-1:0] solar_ext;

	assign battery_ext = EXT_W'(samples.payload.battery_sample);
	assign solar_ext   = EXT_W'(samples.payload.solar_sample);

	// Next-state logic of the sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_next = ST_READ;
				end
			end
			ST_READ:   state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_DIV_AVG;
			ST_DIV_AVG: begin
				if (step_q == '0) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL:    state_next = ST_DIV_MV;
			ST_DIV_MV: begin
				if (step_q == '0) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || averages.ready) begin
					state_next = ST_IDLE;
				end
			end
			default:   state_next = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:    ctrl.in_ready  = 1'b1;
			ST_READ:    ctrl.ram_rd_en = 1'b1;
			ST_UPDATE:  ctrl.ram_wr_en = 1'b1;
			ST_DIV_AVG: ctrl.div_step  = 1'b1;
			ST_DIV_MV:  ctrl.div_step  = 1'b1;
			default:    ctrl = '0;
		endcase
	end

	assign ld_out = (state_q == ST_FINISH) && (!out_valid_q || averages.ready);

	assign samples.ready    = ctrl.in_ready;
	assign averages.valid   = out_valid_q;
	assign averages.payload = out_q;

	// Slot advance and the sample count that the mean is taken over. The count is never
	// zero because the new sample is always part of the window.
	assign slot_inc  = {1'b0, slot_q} + 1'b1;
	assign wrap      = (slot_inc == (SLOT_W + 1)'(WINDOW_LEN));
	assign full_next = full_q || wrap;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			old_sample[l] = ram_rd_data[l*SAMPLE_BITS +: SAMPLE_BITS];
			sum_new[l] = sum_q[l] - (full_q ? SUM_W'(old_sample[l]) : SUM_W'(0))
				+ SUM_W'(sample_q[l]);
		end
	end

	// One restoring-division step per lane: the top dividend bit joins the remainder,
	// and the quotient bit shifts in at the bottom of the same register.
	assign divisor = (state_q == ST_DIV_AVG) ? DVR_W'(count_q) : DVR_W'(FULL_SCALE);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			partial[l]    = {rem_q[l], div_d_q[l][DIV_W-1]};
			diff[l]       = partial[l] - {1'b0, divisor};
			ge[l]         = (partial[l] >= {1'b0, divisor});
			rem_next[l]   = ge[l] ? diff[l][DVR_W-1:0] : partial[l][DVR_W-1:0];
			div_d_next[l] = {div_d_q[l][DIV_W-2:0], ge[l]};
			mv[l] = MV_W'(div_d_q[l][SPAN_W-1:0] * DIVIDER_FACTOR);
		end
	end

	assign ram_wr_data = {sample_q[LANE_SOLAR], sample_q[LANE_BATTERY]};

	// The leaving entry is only fetched once the window has filled, so every read hits an
	// entry that has already been written.
	dcmav_ram #(
		.WIDTH  (LANES * SAMPLE_BITS),
		.DEPTH  (WINDOW_LEN),
		.ADDR_W (SLOT_W)
	) u_window_ram (
		.clk     (clk),
		.wr_en   (ctrl.ram_wr_en),
		.wr_addr (slot_q),
		.wr_data (ram_wr_data),
		.rd_en   (ctrl.ram_rd_en && full_q),
		.rd_addr (slot_q),
		.rd_data (ram_rd_data)
	);

	// Control state: sequencer, slot, fill flag, running sums, step counter and the
	// output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_UPDATE) begin
				slot_q <= wrap ? '0 : slot_inc[SLOT_W-1:0];
				full_q <= full_next;
				sum_q  <= sum_new;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (state_q == ST_MUL) begin
				step_q <= STEP_W'(DIV_W - 1);
			end else if (ctrl.div_step && step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (samples.valid && ctrl.in_ready) begin
			sample_q[LANE_BATTERY] <= battery_ext[SAMPLE_BITS-1:0];
			sample_q[LANE_SOLAR]   <= solar_ext[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_UPDATE) begin
			count_q <= full_next ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_inc);
		end
		for (int l = 0; l < LANES; l++) begin
			if (state_q == ST_UPDATE) begin
				// Left-align the sum so that SUM_W steps consume all of its bits.
				div_d_q[l] <= DIV_W'(sum_new[l]) << (DIV_W - SUM_W);
				rem_q[l]   <= '0;
			end else if (state_q == ST_MUL) begin
				div_d_q[l] <= DIV_W'(avg_q[l] * PROD_W'(PIN_MV_SPAN));
				rem_q[l]   <= '0;
			end else if (ctrl.div_step) begin
				div_d_q[l] <= div_d_next[l];
				rem_q[l]   <= rem_next[l];
			end
			// The mean never exceeds full scale, so its low bits are the whole quotient.
			if (state_q == ST_DIV_AVG && step_q == '0) begin
				avg_q[l] <= div_d_next[l][SAMPLE_BITS-1:0];
			end
		end
		if (ld_out) begin
			out_q.battery_avg_raw    <= AVG_W'(avg_q[LANE_BATTERY]);
			out_q.solar_avg_raw      <= AVG_W'(avg_q[LANE_SOLAR]);
			out_q.battery_millivolts <= mv[LANE_BATTERY];
			out_q.solar_millivolts   <= mv[LANE_SOLAR];
		end
	end

	// An accepted sample transaction always starts the window read.
	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> state_q == ST_READ)
		else $error("accepted sample did not start the window read");

	// A result only appears when the sequencer has finished both division passes.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	// The mean is always taken over between one and WINDOW_LEN samples.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_AVG |-> count_q != '0 && count_q <= CNT_W'(WINDOW_LEN))
		else $error("sample count out of range during averaging");

	// The write slot never leaves the window.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(WINDOW_LEN) || WINDOW_LEN == (1 << SLOT_W))
		else $error("write slot outside the window");

endmodule

`default_nettype wire
